// File: design/lwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwa_pkg: shared types and constants of the advection stencil unit
// sizes, operation codes, register indexes and the update request formats
// ----------------------------------------------------------------------------
package lwa_pkg;

  localparam int MAX_CELLS = 2048;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 30;
  localparam int FRAC_W    = 30;
  localparam int STEP_W    = 16;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;

  // host operations
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_COURANT    = 2'd0,
    REG_HALF_COURANT_SQ = 2'd1,
    REG_STEP_COUNT      = 2'd2,
    REG_GRID_LENGTH     = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  // one stencil update request into the arithmetic pipeline
  typedef struct packed {
    logic                       valid;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] right;
  } upd_req_t;

  // write-back of one updated cell
  typedef struct packed {
    logic                       valid;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

// File: design/lwa_tap_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwa_tap_cell: one cell of the stencil window
// holds one sample and passes it to the next cell whenever the window advances
// ----------------------------------------------------------------------------
module lwa_tap_cell (
  input  wire logic                                 clk,
  input  wire logic                                 shift_en,
  input  wire logic signed [lwa_pkg::SAMPLE_W-1:0]  d,
  output logic signed [lwa_pkg::SAMPLE_W-1:0]       q
);

  logic signed [lwa_pkg::SAMPLE_W-1:0] q_r;

  // sample register
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// File: design/lwa_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwa_update: six-stage Lax-Wendroff cell update
// differences, split products, exact combine, rounding and saturation
// ----------------------------------------------------------------------------
module lwa_update (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [lwa_pkg::COEF_W-1:0]          h,
  input  wire logic [lwa_pkg::COEF_W-1:0]          g,
  input  wire lwa_pkg::upd_req_t                   req,
  output lwa_pkg::wr_t                             wr,
  output logic                                     pipe_busy
);

  localparam int SW  = lwa_pkg::SAMPLE_W;
  localparam int CW  = lwa_pkg::COEF_W;
  localparam int AW  = lwa_pkg::ADDR_W;
  localparam int D1W = SW + 1;
  localparam int D2W = SW + 2;
  localparam int LOW = (D2W + 1) / 2;
  localparam int H2W = D2W - LOW;
  localparam int H1W = D1W - LOW;
  localparam int PW  = 64;
  localparam int TW  = PW + 1;
  localparam int DW  = PW + 1 - lwa_pkg::FRAC_W;
  localparam int RW  = SW + 4;

  // stage valids and addresses
  logic [5:0]          v_r;
  logic [AW-1:0]       a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic signed [SW-1:0] m1_r, m2_r, m3_r, m4_r, m5_r;

  // stage 1: differences
  logic signed [D1W-1:0] d1_nxt, d1_r;
  logic signed [D2W-1:0] d2_nxt, d2_r;

  assign d1_nxt = {req.right[SW-1], req.right} - {req.left[SW-1], req.left};
  assign d2_nxt = {{2{req.right[SW-1]}}, req.right} + {{2{req.left[SW-1]}}, req.left}
                - {req.mid[SW-1], req.mid, 1'b0};

  // stage 2: magnitudes and split partial products
  logic [D2W-1:0]     mag2;
  logic [D1W-1:0]     mag1;
  logic [CW+LOW-1:0]  pa_lo_r, pb_lo_r;
  logic [CW+H2W-1:0]  pa_hi_r;
  logic [CW+H1W-1:0]  pb_hi_r;
  logic               na2_r, nb2_r, na3_r, nb3_r;

  assign mag2 = d2_r[D2W-1] ? D2W'(-d2_r) : D2W'(d2_r);
  assign mag1 = d1_r[D1W-1] ? D1W'(-d1_r) : D1W'(d1_r);

  // stage 3: full products
  logic [PW-1:0] ma_r, mb_r;

  // stage 4: signed combine
  logic signed [TW-1:0] sa, sb, t_r;

  assign sa = na3_r ? -$signed({1'b0, ma_r}) : $signed({1'b0, ma_r});
  assign sb = nb3_r ? -$signed({1'b0, mb_r}) : $signed({1'b0, mb_r});

  // stage 5: magnitude and round half away from zero
  logic [PW-1:0]  tmag;
  logic [PW:0]    rsum;
  logic [DW-1:0]  delta_r;
  logic           neg_r;

  assign tmag = t_r[TW-1] ? PW'(-t_r) : PW'(t_r);
  assign rsum = {1'b0, tmag} + (TW'(1) << (lwa_pkg::FRAC_W - 1));

  // stage 6: apply and saturate
  logic signed [RW-1:0] res;
  logic signed [SW-1:0] sat;
  logic signed [SW-1:0] data6_r;

  assign res = neg_r ? ({{(RW-SW){m5_r[SW-1]}}, m5_r} - $signed({1'b0, delta_r}))
                     : ({{(RW-SW){m5_r[SW-1]}}, m5_r} + $signed({1'b0, delta_r}));

  always_comb begin
    if (res > $signed({{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}})) begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end else if (res < $signed({{(RW-SW+1){1'b1}}, {(SW-1){1'b0}}})) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = res[SW-1:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], req.valid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    m1_r    <= req.mid;
    a1_r    <= req.addr;
    pa_lo_r <= (CW+LOW)'(g) * (CW+LOW)'(mag2[LOW-1:0]);
    pa_hi_r <= (CW+H2W)'(g) * (CW+H2W)'(mag2[D2W-1:LOW]);
    pb_lo_r <= (CW+LOW)'(h) * (CW+LOW)'(mag1[LOW-1:0]);
    pb_hi_r <= (CW+H1W)'(h) * (CW+H1W)'(mag1[D1W-1:LOW]);
    na2_r   <= d2_r[D2W-1];
    nb2_r   <= !d1_r[D1W-1] && (d1_r != '0);
    m2_r    <= m1_r;
    a2_r    <= a1_r;
    ma_r    <= (PW'(pa_hi_r) << LOW) + PW'(pa_lo_r);
    mb_r    <= (PW'(pb_hi_r) << LOW) + PW'(pb_lo_r);
    na3_r   <= na2_r;
    nb3_r   <= nb2_r;
    m3_r    <= m2_r;
    a3_r    <= a2_r;
    t_r     <= sa + sb;
    m4_r    <= m3_r;
    a4_r    <= a3_r;
    delta_r <= rsum[PW:lwa_pkg::FRAC_W];
    neg_r   <= t_r[TW-1];
    m5_r    <= m4_r;
    a5_r    <= a4_r;
    data6_r <= sat;
    a6_r    <= a5_r;
  end

  assign wr.valid  = v_r[5];
  assign wr.addr   = a6_r;
  assign wr.data   = data6_r;
  assign pipe_busy = |v_r;

endmodule
`default_nettype wire

// File: design/lax_wendroff_advection_stencil_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lax_wendroff_advection_stencil_unit: 1-D Lax-Wendroff advection engine
// grid store, host write/read, and a sweep that applies a number of time steps
// ----------------------------------------------------------------------------
// write, read and unused codes: result strobe in the cycle after the request
// run: busy for step_count steps over the L cells in use; each step is
//   one read-port sweep (one cell per cycle) plus the window/update drain
// run with fewer than three cells or zero steps: result in the cycle after the request
// the receiver cannot stall; a new request is taken whenever busy is low
// synchronous reset clears registers and control; the grid store is not cleared
module lax_wendroff_advection_stencil_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [lwa_pkg::OP_W-1:0]            in_operation,
  input  wire logic [lwa_pkg::ADDR_W-1:0]          in_cell_index,
  input  wire logic signed [lwa_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                     out_valid,
  output logic signed [lwa_pkg::SAMPLE_W-1:0]      out_sample_out,
  output logic                                     out_status,
  input  wire logic                                cfg_write_en,
  input  wire logic [lwa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lwa_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW = lwa_pkg::ADDR_W;
  localparam int LW = lwa_pkg::LEN_W;
  localparam int SW = lwa_pkg::SAMPLE_W;

  // configuration registers
  logic [lwa_pkg::COEF_W-1:0] h_r, g_r;
  logic [lwa_pkg::STEP_W-1:0] steps_r;
  logic [11:0]                len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r     <= lwa_pkg::COEF_W'(268435456);
      g_r     <= lwa_pkg::COEF_W'(134217728);
      steps_r <= lwa_pkg::STEP_W'(2356);
      len_r   <= 12'd2000;
    end else if (cfg_write_en) begin
      unique case (lwa_pkg::reg_idx_t'(cfg_index))
        lwa_pkg::REG_HALF_COURANT:    h_r     <= cfg_data[lwa_pkg::COEF_W-1:0];
        lwa_pkg::REG_HALF_COURANT_SQ: g_r     <= cfg_data[lwa_pkg::COEF_W-1:0];
        lwa_pkg::REG_STEP_COUNT:      steps_r <= cfg_data[lwa_pkg::STEP_W-1:0];
        lwa_pkg::REG_GRID_LENGTH:     len_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // effective grid length
  logic [LW-1:0] live_len;
  assign live_len = (13'(len_r) > 13'(lwa_pkg::MAX_CELLS)) ? LW'(lwa_pkg::MAX_CELLS)
                                                           : LW'(len_r);

  // request decode
  logic accept, op_wr, op_rd, op_run, idx_ok, run_ok;
  assign accept = start && !busy;
  assign op_wr  = (in_operation == lwa_pkg::OP_WRITE);
  assign op_rd  = (in_operation == lwa_pkg::OP_READ);
  assign op_run = (in_operation == lwa_pkg::OP_RUN);
  assign idx_ok = (LW'(in_cell_index) < live_len);
  assign run_ok = (live_len >= LW'(3)) && (steps_r != '0);

  // sequencer
  lwa_pkg::state_t            state_r, state_nxt;
  logic [LW-1:0]              rd_cnt_r, rd_cnt_nxt;
  logic [lwa_pkg::STEP_W-1:0] step_cnt_r, step_cnt_nxt;
  logic                       sweep_rd, run_done, inflight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lwa_pkg::ST_IDLE;
      rd_cnt_r   <= '0;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rd_cnt_nxt   = rd_cnt_r;
    step_cnt_nxt = step_cnt_r;
    sweep_rd     = 1'b0;
    run_done     = 1'b0;
    unique case (state_r)
      lwa_pkg::ST_IDLE: begin
        if (accept && op_run && run_ok) begin
          state_nxt    = lwa_pkg::ST_SWEEP;
          rd_cnt_nxt   = '0;
          step_cnt_nxt = '0;
        end
      end
      lwa_pkg::ST_SWEEP: begin
        sweep_rd   = 1'b1;
        rd_cnt_nxt = rd_cnt_r + LW'(1);
        if (rd_cnt_r == live_len - LW'(1)) begin
          state_nxt = lwa_pkg::ST_DRAIN;
        end
      end
      lwa_pkg::ST_DRAIN: begin
        if (!inflight) begin
          if (step_cnt_r + lwa_pkg::STEP_W'(1) == steps_r) begin
            state_nxt = lwa_pkg::ST_IDLE;
            run_done  = 1'b1;
          end else begin
            state_nxt    = lwa_pkg::ST_SWEEP;
            rd_cnt_nxt   = '0;
            step_cnt_nxt = step_cnt_r + lwa_pkg::STEP_W'(1);
          end
        end
      end
      default: state_nxt = lwa_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != lwa_pkg::ST_IDLE);

  // grid store, one write and one registered read port
  logic signed [SW-1:0] mem [lwa_pkg::MAX_CELLS];
  logic signed [SW-1:0] mem_rdata_r;
  logic                 host_we, mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic signed [SW-1:0] mem_wdata;
  lwa_pkg::wr_t         wr;

  assign host_we   = accept && op_wr && idx_ok;
  assign mem_we    = host_we || wr.valid;
  assign mem_waddr = wr.valid ? wr.addr : in_cell_index;
  assign mem_wdata = wr.valid ? wr.data : in_sample_in;
  assign mem_raddr = sweep_rd ? rd_cnt_r[AW-1:0] : in_cell_index;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // sweep read tag
  logic          rd_valid_r;
  logic [AW-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= sweep_rd;
    end
    rd_idx_r <= rd_cnt_r[AW-1:0];
  end

  // stencil window: two cells behind the incoming sample
  logic signed [SW-1:0] tap0_q, tap1_q;

  lwa_tap_cell u_tap0 (
    .clk      (clk),
    .shift_en (rd_valid_r),
    .d        (mem_rdata_r),
    .q        (tap0_q)
  );

  lwa_tap_cell u_tap1 (
    .clk      (clk),
    .shift_en (rd_valid_r),
    .d        (tap0_q),
    .q        (tap1_q)
  );

  // update request for cell k-1 once cell k arrives
  lwa_pkg::upd_req_t req;
  logic              pipe_busy;

  assign req.valid = rd_valid_r && (rd_idx_r >= AW'(2));
  assign req.addr  = rd_idx_r - AW'(1);
  assign req.left  = tap1_q;
  assign req.mid   = tap0_q;
  assign req.right = mem_rdata_r;

  lwa_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .h         (h_r),
    .g         (g_r),
    .req       (req),
    .wr        (wr),
    .pipe_busy (pipe_busy)
  );

  assign inflight = rd_valid_r || pipe_busy;

  // result register
  logic out_valid_r, out_status_r, out_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_rd_r     <= 1'b0;
    end else begin
      out_valid_r  <= (accept && !(op_run && run_ok)) || run_done;
      out_status_r <= accept && (op_wr || op_rd) && !idx_ok;
      out_rd_r     <= accept && op_rd && idx_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_sample_out = out_rd_r ? mem_rdata_r : '0;

endmodule
`default_nettype wire

// File: design/lwa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwa_checker: port-level checks of the advection stencil unit
// result timing against busy and request acceptance
// ----------------------------------------------------------------------------
module lwa_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic [lwa_pkg::OP_W-1:0]            in_operation,
  input wire logic                                out_valid,
  input wire logic signed [lwa_pkg::SAMPLE_W-1:0] out_sample_out,
  input wire logic                                out_status
);

  // no result while a run is in progress
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // a non-run request answers in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != lwa_pkg::OP_RUN) |=> out_valid)
    else $error("missing result after request");

  // a run ends with its result
  a_run_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("run ended without result");

  // an index error carries no sample
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_sample_out == '0))
    else $error("sample on index error");

endmodule

bind lax_wendroff_advection_stencil_unit lwa_checker u_lwa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_sample_out (out_sample_out),
  .out_status     (out_status)
);
`default_nettype wire

// File: tb/lax_wendroff_advection_stencil_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lax_wendroff_advection_stencil_unit_tb: self-checking bench of the stencil unit
// drives write, read, run and unused requests against an in-bench copy of the
// grid and the coefficients, and compares every result strobe in order
// ----------------------------------------------------------------------------
module lax_wendroff_advection_stencil_unit_tb;

  typedef struct {
    logic signed [lwa_pkg::SAMPLE_W-1:0] sample;
    logic                                status;
  } lw_result_t;

  // operation code with no action
  localparam logic [lwa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [lwa_pkg::OP_W-1:0]            in_operation = '0;
  logic [lwa_pkg::ADDR_W-1:0]          in_cell_index = '0;
  logic signed [lwa_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic                                out_valid;
  logic signed [lwa_pkg::SAMPLE_W-1:0] out_sample_out;
  logic                                out_status;
  logic                                cfg_write_en = 1'b0;
  logic [lwa_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [lwa_pkg::CFG_W-1:0]           cfg_data = '0;

  // shadow of the unit: coefficients, sizes and grid
  logic [lwa_pkg::COEF_W-1:0]          h_coef;
  logic [lwa_pkg::COEF_W-1:0]          g_coef;
  logic [lwa_pkg::STEP_W-1:0]          steps_per_run;
  logic [11:0]                         grid_len;
  logic signed [lwa_pkg::SAMPLE_W-1:0] grid_shadow [lwa_pkg::MAX_CELLS];
  bit                                  cell_loaded [lwa_pkg::MAX_CELLS];
  lw_result_t                          pending_results [$];

  int  errors = 0;
  int  n_requests = 0;
  int  n_runs = 0;
  int  n_oob = 0;
  int  n_checked = 0;
  bit  start_high = 1'b0;
  bit  no_idle = 1'b0;

  lax_wendroff_advection_stencil_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_cell_index  (in_cell_index),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_status     (out_status),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int live_cells();
    return (grid_len > lwa_pkg::MAX_CELLS) ? lwa_pkg::MAX_CELLS : int'(grid_len);
  endfunction

  // one cell update: exact products, round half away from zero, saturate
  function automatic logic signed [lwa_pkg::SAMPLE_W-1:0] lw_update(longint l, longint m,
                                                                    longint r);
    longint      d1, d2, delta, res;
    logic [63:0] ad1, ad2, ma, mb, mag;
    bit          na, nb, neg;
    d1 = r - l;
    d2 = r + l - 2 * m;
    ad1 = (d1 < 0) ? -d1 : d1;
    ad2 = (d2 < 0) ? -d2 : d2;
    ma = 64'(g_coef) * ad2;
    mb = 64'(h_coef) * ad1;
    na = d2 < 0;
    nb = d1 > 0;
    if (na == nb) begin
      mag = ma + mb;
      neg = na;
    end else if (ma >= mb) begin
      mag = ma - mb;
      neg = na;
    end else begin
      mag = mb - ma;
      neg = nb;
    end
    mag = (mag + (64'd1 << (lwa_pkg::FRAC_W - 1))) >> lwa_pkg::FRAC_W;
    delta = longint'(mag);
    res = neg ? m - delta : m + delta;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[lwa_pkg::SAMPLE_W-1:0];
  endfunction

  // apply one accepted request to the shadow and queue its result
  function automatic void predict_request(logic [lwa_pkg::OP_W-1:0] op, int idx,
                                          logic signed [lwa_pkg::SAMPLE_W-1:0] val);
    lw_result_t                          r;
    int                                  n;
    logic signed [lwa_pkg::SAMPLE_W-1:0] prev [lwa_pkg::MAX_CELLS];
    r.sample = '0;
    r.status = 1'b0;
    n = live_cells();
    if (op == lwa_pkg::OP_WRITE || op == lwa_pkg::OP_READ) begin
      if (idx >= n) begin
        r.status = 1'b1;
        n_oob++;
      end else if (op == lwa_pkg::OP_WRITE) begin
        grid_shadow[idx] = val;
        cell_loaded[idx] = 1'b1;
      end else begin
        r.sample = grid_shadow[idx];
      end
    end else if (op == lwa_pkg::OP_RUN) begin
      n_runs++;
      if (n >= 3) begin
        for (int s = 0; s < steps_per_run; s++) begin
          prev = grid_shadow;
          for (int i = 1; i < n - 1; i++)
            grid_shadow[i] = lw_update(prev[i-1], prev[i], prev[i+1]);
        end
      end
    end
    pending_results.push_back(r);
  endfunction

  // result checker
  always @(posedge clk) begin
    lw_result_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_sample_out !== e.sample) begin
          $error("sample_out: expected %h, got %h", e.sample, out_sample_out);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  function automatic int idle_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // send one request and wait for it to be taken
  task automatic send_request(logic [lwa_pkg::OP_W-1:0] op, int idx,
                              logic signed [lwa_pkg::SAMPLE_W-1:0] val);
    int gap;
    start <= 1'b1;
    start_high = 1'b1;
    in_operation <= op;
    in_cell_index <= idx[lwa_pkg::ADDR_W-1:0];
    in_sample_in <= val;
    do @(posedge clk); while (busy !== 1'b0);
    predict_request(op, idx, val);
    n_requests++;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      start_high = 1'b0;
      in_operation <= lwa_pkg::OP_W'($urandom_range(3));
      in_cell_index <= lwa_pkg::ADDR_W'($urandom);
      in_sample_in <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every result is back and the unit has settled
  task automatic wait_quiet();
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
    do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(lwa_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= lwa_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      lwa_pkg::REG_HALF_COURANT:    h_coef = lwa_pkg::COEF_W'(val);
      lwa_pkg::REG_HALF_COURANT_SQ: g_coef = lwa_pkg::COEF_W'(val);
      lwa_pkg::REG_STEP_COUNT:      steps_per_run = val[lwa_pkg::STEP_W-1:0];
      default:                      grid_len = val[11:0];
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [lwa_pkg::SAMPLE_W-1:0] rand_sample();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 32'sh7fffffff - $urandom_range(3);
    if (p == 1) return 32'sh80000000 + $urandom_range(3);
    if (p < 5) return $signed($urandom) >>> $urandom_range(8, 2);
    return $urandom;
  endfunction

  // load any cell in use that was never written, so a run reads defined data
  task automatic fill_unloaded();
    for (int i = 0; i < live_cells(); i++)
      if (!cell_loaded[i]) send_request(lwa_pkg::OP_WRITE, i, rand_sample());
  endtask

  // reset coefficients, extremes of samples and indexes, every operation
  task automatic test_directed_basics();
    write_reg(lwa_pkg::REG_GRID_LENGTH, 8);
    write_reg(lwa_pkg::REG_STEP_COUNT, 2);
    send_request(lwa_pkg::OP_WRITE, 0, 32'sh7fffffff);
    send_request(lwa_pkg::OP_WRITE, 1, 32'sh80000000);
    send_request(lwa_pkg::OP_WRITE, 2, 0);
    send_request(lwa_pkg::OP_WRITE, 3, -1);
    for (int i = 4; i < 8; i++) send_request(lwa_pkg::OP_WRITE, i, rand_sample());
    send_request(lwa_pkg::OP_READ, 0, 0);
    send_request(lwa_pkg::OP_READ, 1, 0);
    send_request(lwa_pkg::OP_RUN, 0, 0);
    for (int i = 0; i < 8; i++) send_request(lwa_pkg::OP_READ, i, 0);
    // index at and far beyond the length, then the unused code
    send_request(lwa_pkg::OP_WRITE, 8, 32'sh5a5a5a5a);
    send_request(lwa_pkg::OP_READ, 2047, 0);
    send_request(OP_UNUSED, 3, 32'sh12345678);
    send_request(lwa_pkg::OP_READ, 3, 0);
    wait_quiet();
  endtask

  // largest coefficients drive the update into saturation
  task automatic test_saturation();
    write_reg(lwa_pkg::REG_HALF_COURANT, {2'b00, {lwa_pkg::CFG_W{1'b1}}});
    write_reg(lwa_pkg::REG_HALF_COURANT_SQ, {2'b00, {lwa_pkg::CFG_W{1'b1}}});
    write_reg(lwa_pkg::REG_STEP_COUNT, 3);
    write_reg(lwa_pkg::REG_GRID_LENGTH, 5);
    send_request(lwa_pkg::OP_WRITE, 0, 32'sh80000000);
    send_request(lwa_pkg::OP_WRITE, 1, 32'sh7fffffff);
    send_request(lwa_pkg::OP_WRITE, 2, 32'sh80000000);
    send_request(lwa_pkg::OP_WRITE, 3, 32'sh7fffffff);
    send_request(lwa_pkg::OP_WRITE, 4, 32'sh80000000);
    send_request(lwa_pkg::OP_RUN, 0, 0);
    for (int i = 0; i < 5; i++) send_request(lwa_pkg::OP_READ, i, 0);
    wait_quiet();
    write_reg(lwa_pkg::REG_HALF_COURANT, 0);
    write_reg(lwa_pkg::REG_HALF_COURANT_SQ, 0);
    send_request(lwa_pkg::OP_RUN, 0, 0);
    send_request(lwa_pkg::OP_READ, 2, 0);
    wait_quiet();
  endtask

  // runs that must leave the grid alone
  task automatic test_empty_runs();
    write_reg(lwa_pkg::REG_HALF_COURANT, 1 << 29);
    write_reg(lwa_pkg::REG_HALF_COURANT_SQ, 1 << 29);
    write_reg(lwa_pkg::REG_STEP_COUNT, 16'hffff);
    for (int len = 0; len < 3; len++) begin
      write_reg(lwa_pkg::REG_GRID_LENGTH, len);
      send_request(lwa_pkg::OP_RUN, 0, 0);
      send_request(lwa_pkg::OP_READ, len, 0);
      wait_quiet();
    end
    write_reg(lwa_pkg::REG_GRID_LENGTH, 5);
    write_reg(lwa_pkg::REG_STEP_COUNT, 0);
    send_request(lwa_pkg::OP_RUN, 0, 0);
    send_request(lwa_pkg::OP_READ, 1, 0);
    wait_quiet();
  endtask

  // length above the store size is limited to the full store
  task automatic test_full_grid();
    write_reg(lwa_pkg::REG_GRID_LENGTH, 12'hfff);
    send_request(lwa_pkg::OP_WRITE, 2047, rand_sample());
    send_request(lwa_pkg::OP_WRITE, 2046, rand_sample());
    send_request(lwa_pkg::OP_READ, 2047, 0);
    send_request(lwa_pkg::OP_READ, 2046, 0);
    wait_quiet();
    write_reg(lwa_pkg::REG_GRID_LENGTH, 2048);
    send_request(lwa_pkg::OP_READ, 2047, 0);
    wait_quiet();
    // last cell just outside the length
    write_reg(lwa_pkg::REG_GRID_LENGTH, 2047);
    send_request(lwa_pkg::OP_WRITE, 2047, rand_sample());
    send_request(lwa_pkg::OP_READ, 2047, 0);
    send_request(lwa_pkg::OP_READ, 2046, 0);
    wait_quiet();
  endtask

  // random phases: small grids, random coefficients and mixed requests
  task automatic test_random_phases();
    int target, idx, p, n;
    target = n_requests + 900;
    while (n_requests < target) begin
      p = $urandom_range(9);
      write_reg(lwa_pkg::REG_GRID_LENGTH,
                (p == 0) ? $urandom_range(4095) : $urandom_range(32, 3));
      write_reg(lwa_pkg::REG_STEP_COUNT, (p == 1) ? $urandom_range(60) : $urandom_range(4));
      write_reg(lwa_pkg::REG_HALF_COURANT,
                ($urandom_range(7) == 0) ? $urandom : $urandom_range(1 << 29));
      write_reg(lwa_pkg::REG_HALF_COURANT_SQ,
                ($urandom_range(7) == 0) ? $urandom : $urandom_range(1 << 29));
      no_idle = ($urandom_range(3) == 0);
      n = live_cells();
      for (int k = 0; k < 150 && n_requests < target; k++) begin
        p = $urandom_range(99);
        idx = ($urandom_range(19) == 0) ? $urandom_range(2047)
                                        : $urandom_range((n > 0) ? n - 1 : 0);
        if (p < 8 && n <= 64) begin
          fill_unloaded();
          send_request(lwa_pkg::OP_RUN, $urandom_range(2047), $urandom);
        end else if (p < 12) begin
          send_request(OP_UNUSED, $urandom_range(2047), $urandom);
        end else if (p < 55 && (idx >= n || cell_loaded[idx])) begin
          send_request(lwa_pkg::OP_READ, idx, $urandom);
        end else begin
          send_request(lwa_pkg::OP_WRITE, idx, rand_sample());
        end
      end
      wait_quiet();
    end
  endtask

  initial begin
    h_coef = 30'd268435456;
    g_coef = 30'd134217728;
    steps_per_run = 16'd2356;
    grid_len = 12'd2000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_basics();
    test_saturation();
    test_empty_runs();
    test_random_phases();
    test_full_grid();
    wait_quiet();
    $display("covered %0d requests (%0d runs, %0d out of range), %0d results checked",
             n_requests, n_runs, n_oob, n_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[lax_wendroff_advection_stencil_unit] OK");
    end else begin
      $display("[lax_wendroff_advection_stencil_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("[lax_wendroff_advection_stencil_unit] ERROR");
    $finish;
  end

endmodule
